// ===== rtl/a2a_trk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2a_trk_pkg
// Shared types and codes of the all-to-all collective tracker.
// ----------------------------------------------------------------------------
package a2a_trk_pkg;

   localparam int RANK_W = 3;
   localparam int FLOW_W = 16;
   localparam int SIZE_W = 32;

   localparam logic OP_START  = 1'b0;
   localparam logic OP_PACKET = 1'b1;

   localparam logic KIND_SEND = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   localparam logic [1:0] MODE_RING   = 2'd0;
   localparam logic [1:0] MODE_DIRECT = 2'd1;
   localparam logic [1:0] MODE_GRID   = 2'd2;

   localparam logic [2:0] REG_GPU_COUNT     = 3'd0;
   localparam logic [2:0] REG_CHUNK_BYTES   = 3'd1;
   localparam logic [2:0] REG_MODE          = 3'd2;
   localparam logic [2:0] REG_GRID_COLS     = 3'd3;
   localparam logic [2:0] REG_WIRE_PROTOCOL = 3'd4;

   localparam logic [15:0] FIRST_HOP_MARK = 16'h8000;
   localparam logic [15:0] FINAL_MASK     = 16'h7fff;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_START = 4'b0010,
      ST_PKT   = 4'b0100,
      ST_UPD   = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      PATH_RING   = 2'd0,
      PATH_DIRECT = 2'd1,
      PATH_HOP    = 2'd2
   } path_type;

endpackage

// ===== rtl/a2a_trk_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// a2a_trk_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module a2a_trk_ram #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== rtl/alltoall_collective_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alltoall_collective_tracker_core
// All-to-all collective scheduler and tracker: start items issue the initial
// sends, packet items update byte counters and raise follow-up results.
// ----------------------------------------------------------------------------
// Steps: a packet passes the accept and counter read states and, if valid,
// the update state, and gives at most one result; a start walks every rank
// pair in direct/grid mode (no send for a rank to itself) and every rank in
// ring mode, one send per cycle from the shared sequencer unless the output stalls.
// Throughput: one transaction in flight; an output stall holds the state.
// Reset: synchronous, active high; clears counters, valid bits, state, config.
// ----------------------------------------------------------------------------
module alltoall_collective_tracker_core #(
   parameter int MAX_RANKS  = 8,
   parameter int COUNT_BITS = 40
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] src_rank, [5:3] dest_rank, [21:6] flow_tag,
   // [53:22] header_bytes, [85:54] packet_bytes, [87:86] zero
   input  logic [87:0] req_tdata,
   // [0] op, [1] is_data
   input  logic [1:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] send_source, [5:3] send_target, [21:6] send_flow, [23:22] send_protocol
   output logic [23:0] rsp_tdata,
   // [0] kind
   output logic        rsp_tuser,
   output logic        rsp_tlast,
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int RIDX_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
   localparam int FH_DEPTH = MAX_RANKS * MAX_RANKS;
   localparam int FH_AW = $clog2(FH_DEPTH);
   localparam int THR_W = 36;
   localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // configuration registers
   logic [3:0]  gpu_count_ff;
   logic [31:0] chunk_ff;
   logic [1:0]  mode_ff;
   logic [3:0]  grid_cols_ff;
   logic [1:0]  proto_ff;

   // tracking state
   logic [2:0]            ring_step_done_ff  [MAX_RANKS];
   logic [COUNT_BITS-1:0] ring_step_bytes_ff [MAX_RANKS];
   logic [COUNT_BITS-1:0] direct_bytes_ff    [MAX_RANKS];
   logic [2:0]            sources_done_ff    [MAX_RANKS];
   logic [FH_DEPTH-1:0]   fh_valid_ff;
   logic [3:0]            ranks_done_ff;

   a2a_trk_pkg::state_type state_ff, state_in;
   a2a_trk_pkg::path_type  path_ff, path_in;

   // sequencer counters
   logic [2:0] g_ff, g_in, d_ff, d_in;
   logic [3:0] sr_ff, sr_in, sc_ff, sc_in, dr_ff, dr_in, dc_ff, dc_in;

   // latched packet
   logic [2:0]  p_src_ff, p_dst_ff;
   logic [15:0] p_flow_ff;
   logic        p_data_ff;
   logic [31:0] p_hdr_ff, p_pkt_ff;
   logic [31:0] size_ff, size_in;
   logic [THR_W-1:0] thr_ff, thr_in;
   logic [FH_AW-1:0] fh_addr_ff, fh_addr_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        o_kind_ff, o_last_ff;
   logic [2:0]  o_src_ff, o_tgt_ff;
   logic [15:0] o_flow_ff;
   logic [1:0]  o_proto_ff;

   // emit request from the sequencer
   logic        emit, e_kind, e_last;
   logic [2:0]  e_src, e_tgt;
   logic [15:0] e_flow;
   logic        out_free, advance;

   logic [3:0] n, cols, nm1;
   logic [RIDX_W-1:0] di;
   logic [COUNT_BITS-1:0] fh_q, cur, sat;
   logic [COUNT_BITS:0]   sum;
   logic hit_chunk, hit_thr;
   logic [2:0] step_new, sd_new;
   logic [3:0] rd_new;
   logic [4:0] ring_t;
   logic [7:0] hsum;
   logic [14:0] fin;
   logic fh_we;
   logic [COUNT_BITS-1:0] fh_wd;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == a2a_trk_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {o_proto_ff, o_flow_ff, o_tgt_ff, o_src_ff};
   assign rsp_tuser  = o_kind_ff;
   assign rsp_tlast  = o_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // clamp rank count and grid columns
   always_comb begin
      if (gpu_count_ff < 4'd2) begin
         n = 4'd2;
      end else if (gpu_count_ff > 4'(MAX_RANKS)) begin
         n = 4'(MAX_RANKS);
      end else begin
         n = gpu_count_ff;
      end
      cols = (grid_cols_ff == 4'd0) ? 4'd1 : grid_cols_ff;
      nm1  = n - 4'd1;
   end

   assign di  = p_dst_ff[RIDX_W-1:0];
   assign fin = p_flow_ff[14:0] & a2a_trk_pkg::FINAL_MASK[14:0];

   a2a_trk_ram #(.WIDTH(COUNT_BITS), .DEPTH(FH_DEPTH)) u_first_hop (
      .clock   (clock),
      .wr_en   (fh_we),
      .wr_addr (fh_addr_ff),
      .wr_data (fh_wd),
      .rd_addr (fh_addr_in),
      .rd_data (fh_q)
   );

   // shared counter update: saturating add and compares
   always_comb begin
      case (path_ff)
         a2a_trk_pkg::PATH_HOP:    cur = fh_valid_ff[fh_addr_ff] ? fh_q : '0;
         a2a_trk_pkg::PATH_DIRECT: cur = direct_bytes_ff[di];
         default:                  cur = ring_step_bytes_ff[di];
      endcase
      sum = {1'b0, cur} + (COUNT_BITS + 1)'(size_ff);
      sat = sum[COUNT_BITS] ? CNT_MAX : sum[COUNT_BITS-1:0];
      hit_chunk = sat >= COUNT_BITS'(chunk_ff);
      hit_thr   = CMP_W'(sat) >= CMP_W'(thr_ff);
      step_new  = (ring_step_done_ff[di] == 3'd7) ? 3'd7 : ring_step_done_ff[di] + 3'd1;
      sd_new    = (sources_done_ff[di] == 3'd7) ? 3'd7 : sources_done_ff[di] + 3'd1;
      rd_new    = (ranks_done_ff == 4'd15) ? 4'd15 : ranks_done_ff + 4'd1;
      ring_t    = 5'(p_dst_ff) + 5'(step_new) + 5'd1;
      if (ring_t >= 5'(n)) begin
         ring_t = ring_t - 5'(n);
      end
      hsum = 8'(sr_ff) * 8'(cols) + 8'(dc_ff);
      fh_wd = hit_chunk ? '0 : sat;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      path_in  = path_ff;
      g_in = g_ff; d_in = d_ff;
      sr_in = sr_ff; sc_in = sc_ff; dr_in = dr_ff; dc_in = dc_ff;
      size_in = size_ff;
      thr_in  = thr_ff;
      fh_addr_in = fh_addr_ff;
      emit = 1'b0; e_kind = a2a_trk_pkg::KIND_SEND; e_last = 1'b0;
      e_src = '0; e_tgt = '0; e_flow = '0;
      advance = 1'b0;
      fh_we = 1'b0;
      case (state_ff)
         a2a_trk_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               g_in = '0; d_in = '0;
               sr_in = '0; sc_in = '0; dr_in = '0; dc_in = '0;
               state_in = (req_tuser[0] == a2a_trk_pkg::OP_START) ?
                          a2a_trk_pkg::ST_START : a2a_trk_pkg::ST_PKT;
            end
         end
         a2a_trk_pkg::ST_START: begin
            e_src = g_ff;
            if (mode_ff == a2a_trk_pkg::MODE_RING) begin
               emit   = 1'b1;
               e_tgt  = (4'(g_ff) == nm1) ? 3'd0 : g_ff + 3'd1;
               e_flow = 16'd1;
               e_last = (4'(g_ff) == nm1);
            end else begin
               emit   = (d_ff != g_ff);
               e_tgt  = d_ff;
               e_flow = 16'(d_ff) + 16'd1;
               e_last = (4'(g_ff) == nm1) && (4'(d_ff) == n - 4'd2);
               if (mode_ff == a2a_trk_pkg::MODE_GRID && sr_ff != dr_ff && sc_ff != dc_ff
                   && hsum < 8'(n)) begin
                  e_tgt  = hsum[2:0];
                  e_flow = a2a_trk_pkg::FIRST_HOP_MARK | 16'(d_ff);
               end
            end
            advance = !emit || out_free;
            if (advance) begin
               if (mode_ff == a2a_trk_pkg::MODE_RING) begin
                  if (4'(g_ff) == nm1) begin
                     state_in = a2a_trk_pkg::ST_IDLE;
                  end else begin
                     g_in = g_ff + 3'd1;
                  end
               end else if (4'(d_ff) == nm1) begin
                  d_in = '0; dr_in = '0; dc_in = '0;
                  if (4'(g_ff) == nm1) begin
                     state_in = a2a_trk_pkg::ST_IDLE;
                  end else begin
                     g_in = g_ff + 3'd1;
                     if (sc_ff + 4'd1 == cols) begin
                        sc_in = '0; sr_in = sr_ff + 4'd1;
                     end else begin
                        sc_in = sc_ff + 4'd1;
                     end
                  end
               end else begin
                  d_in = d_ff + 3'd1;
                  if (dc_ff + 4'd1 == cols) begin
                     dc_in = '0; dr_in = dr_ff + 4'd1;
                  end else begin
                     dc_in = dc_ff + 4'd1;
                  end
               end
            end
         end
         a2a_trk_pkg::ST_PKT: begin
            // pick the effective size, prefetch the pair counter, scale threshold
            size_in = (p_hdr_ff != 32'd0) ? p_hdr_ff : p_pkt_ff;
            thr_in  = THR_W'(chunk_ff) * THR_W'({1'b0, sources_done_ff[di]} + 4'd1);
            fh_addr_in = FH_AW'(p_src_ff) * FH_AW'(MAX_RANKS) + FH_AW'(fin[2:0]);
            if (mode_ff == a2a_trk_pkg::MODE_GRID && p_flow_ff[15]) begin
               path_in = a2a_trk_pkg::PATH_HOP;
            end else if (mode_ff != a2a_trk_pkg::MODE_RING) begin
               path_in = a2a_trk_pkg::PATH_DIRECT;
            end else begin
               path_in = a2a_trk_pkg::PATH_RING;
            end
            if (!p_data_ff || 4'(p_src_ff) >= n || 4'(p_dst_ff) >= n ||
                (path_in == a2a_trk_pkg::PATH_HOP && fin >= 15'(n))) begin
               state_in = a2a_trk_pkg::ST_IDLE;
            end else begin
               state_in = a2a_trk_pkg::ST_UPD;
            end
         end
         a2a_trk_pkg::ST_UPD: begin
            e_last = 1'b1;
            case (path_ff)
               a2a_trk_pkg::PATH_HOP: begin
                  emit   = hit_chunk;
                  e_src  = p_dst_ff;
                  e_tgt  = fin[2:0];
                  e_flow = 16'(fin) + 16'd1;
               end
               a2a_trk_pkg::PATH_DIRECT: begin
                  emit   = hit_thr && 4'(sd_new) >= nm1 && rd_new >= n;
                  e_kind = a2a_trk_pkg::KIND_DONE;
               end
               default: begin
                  if (4'(step_new) >= nm1) begin
                     emit   = hit_chunk && rd_new >= n;
                     e_kind = a2a_trk_pkg::KIND_DONE;
                  end else begin
                     emit   = hit_chunk;
                     e_src  = p_dst_ff;
                     e_tgt  = ring_t[2:0];
                     e_flow = 16'(step_new) + 16'd1;
                  end
               end
            endcase
            advance = !emit || out_free;
            if (advance) begin
               fh_we    = (path_ff == a2a_trk_pkg::PATH_HOP);
               state_in = a2a_trk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = a2a_trk_pkg::ST_IDLE;
         end
      endcase
      if (emit && !advance) begin
         emit = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= a2a_trk_pkg::ST_IDLE;
         path_ff       <= a2a_trk_pkg::PATH_RING;
         rsp_valid_ff  <= 1'b0;
         gpu_count_ff  <= 4'd2;
         chunk_ff      <= '0;
         mode_ff       <= a2a_trk_pkg::MODE_RING;
         grid_cols_ff  <= 4'd1;
         proto_ff      <= '0;
         ranks_done_ff <= '0;
         fh_valid_ff   <= '0;
         for (int i = 0; i < MAX_RANKS; i++) begin
            ring_step_done_ff[i]  <= '0;
            ring_step_bytes_ff[i] <= '0;
            direct_bytes_ff[i]    <= '0;
            sources_done_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         path_ff      <= path_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               a2a_trk_pkg::REG_GPU_COUNT:     gpu_count_ff <= csr_data[3:0];
               a2a_trk_pkg::REG_CHUNK_BYTES:   chunk_ff     <= csr_data;
               a2a_trk_pkg::REG_MODE:          mode_ff      <= csr_data[1:0];
               a2a_trk_pkg::REG_GRID_COLS:     grid_cols_ff <= csr_data[3:0];
               a2a_trk_pkg::REG_WIRE_PROTOCOL: proto_ff     <= csr_data[1:0];
               default: ;
            endcase
         end
         // commit the counter update once the output register can take the result, if any
         if (state_ff == a2a_trk_pkg::ST_UPD && advance) begin
            case (path_ff)
               a2a_trk_pkg::PATH_HOP: begin
                  fh_valid_ff[fh_addr_ff] <= 1'b1;
               end
               a2a_trk_pkg::PATH_DIRECT: begin
                  direct_bytes_ff[di] <= sat;
                  if (hit_thr) begin
                     sources_done_ff[di] <= sd_new;
                     if (4'(sd_new) >= nm1) begin
                        ranks_done_ff <= rd_new;
                     end
                  end
               end
               default: begin
                  ring_step_bytes_ff[di] <= hit_chunk ? '0 : sat;
                  if (hit_chunk) begin
                     ring_step_done_ff[di] <= step_new;
                     if (4'(step_new) >= nm1) begin
                        ranks_done_ff <= rd_new;
                     end
                  end
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      g_ff <= g_in; d_ff <= d_in;
      sr_ff <= sr_in; sc_ff <= sc_in; dr_ff <= dr_in; dc_ff <= dc_in;
      size_ff <= size_in;
      thr_ff  <= thr_in;
      fh_addr_ff <= fh_addr_in;
      if (req_tvalid && req_tready) begin
         p_src_ff  <= req_tdata[2:0];
         p_dst_ff  <= req_tdata[5:3];
         p_flow_ff <= req_tdata[21:6];
         p_hdr_ff  <= req_tdata[53:22];
         p_pkt_ff  <= req_tdata[85:54];
         p_data_ff <= req_tuser[1];
      end
      if (emit) begin
         o_kind_ff  <= e_kind;
         o_last_ff  <= e_last;
         o_src_ff   <= e_src;
         o_tgt_ff   <= e_tgt;
         o_flow_ff  <= e_flow;
         o_proto_ff <= (e_kind == a2a_trk_pkg::KIND_DONE) ? 2'd0 : proto_ff;
      end
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the all-to-all collective tracker core. Start and
// packet transactions go in on the request stream; a cycle-free tracker
// model kept in the bench predicts every send command and done result, and
// a monitor checks each response, in order, field by field.
// ----------------------------------------------------------------------------
module tb;

   localparam int NR = 8;
   localparam logic [39:0] CNT_MAX = 40'hff_ffff_ffff;
   localparam int TIMEOUT = 2000000;

   typedef struct packed {
      logic        kind;
      logic [2:0]  src;
      logic [2:0]  tgt;
      logic [15:0] flow;
      logic [1:0]  proto;
      logic        last;
   } cmd_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [87:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   alltoall_collective_tracker_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      clock = 1'b0; #4;
      clock = 1'b1; #4;
   end

   // tracker state mirrored by the bench
   logic [3:0]  cfg_gpus;
   logic [31:0] cfg_chunk;
   logic [1:0]  cfg_mode;
   logic [3:0]  cfg_cols;
   logic [1:0]  cfg_proto;
   logic [2:0]  step_done [NR];
   logic [39:0] step_bytes [NR];
   logic [39:0] rank_bytes [NR];
   logic [2:0]  srcs_done [NR];
   logic [39:0] hop_bytes [NR*NR];
   logic [3:0]  done_ranks;

   cmd_type expected_cmds[$];
   cmd_type item_cmds[$];
   int   errors;
   int   send_idle_pct;
   int   rx_stall_pct;
   int   rx_hold;
   int   cycles;

   function automatic int ranks();
      if (cfg_gpus < 2) return 2;
      if (cfg_gpus > NR) return NR;
      return cfg_gpus;
   endfunction

   function automatic logic [39:0] sat_add(logic [39:0] a, logic [31:0] b);
      logic [40:0] s;
      s = {1'b0, a} + 41'(b);
      return s[40] ? CNT_MAX : s[39:0];
   endfunction

   task automatic push_send(int s, int t, int f);
      cmd_type c;
      c.kind = a2a_trk_pkg::KIND_SEND; c.src = 3'(s); c.tgt = 3'(t); c.flow = 16'(f);
      c.proto = cfg_proto; c.last = 1'b0;
      item_cmds.push_back(c);
   endtask

   task automatic count_rank_done(int n);
      cmd_type c;
      if (done_ranks < 15) done_ranks++;
      if (done_ranks >= n) begin
         c = '0; c.kind = a2a_trk_pkg::KIND_DONE;
         item_cmds.push_back(c);
      end
   endtask

   // Work out the commands one request causes and queue them.
   task automatic track_item(logic op, int src, int dst, logic [15:0] flow,
                             logic isd, logic [31:0] hdr, logic [31:0] pkt);
      int n, cols, hop, fl, fin, step, idx;
      logic [31:0] size;
      n = ranks();
      item_cmds.delete();
      if (op == a2a_trk_pkg::OP_START) begin
         cols = (cfg_cols == 0) ? 1 : cfg_cols;
         if (cfg_mode == a2a_trk_pkg::MODE_RING) begin
            for (int g = 0; g < n; g++) push_send(g, (g + 1) % n, 1);
         end else begin
            for (int g = 0; g < n; g++)
               for (int d = 0; d < n; d++) begin
                  if (d == g) continue;
                  hop = d; fl = d + 1;
                  if (cfg_mode == a2a_trk_pkg::MODE_GRID && g / cols != d / cols
                      && g % cols != d % cols) begin
                     if ((g / cols) * cols + d % cols < n) begin
                        hop = (g / cols) * cols + d % cols;
                        fl = a2a_trk_pkg::FIRST_HOP_MARK | d;
                     end
                  end
                  push_send(g, hop, fl);
               end
         end
      end else if (isd && src < n && dst < n) begin
         size = (hdr == 0) ? pkt : hdr;
         if (cfg_mode == a2a_trk_pkg::MODE_GRID && flow[15]) begin
            fin = flow & a2a_trk_pkg::FINAL_MASK;
            if (fin < n) begin
               idx = src * NR + fin;
               hop_bytes[idx] = sat_add(hop_bytes[idx], size);
               if (hop_bytes[idx] >= cfg_chunk) begin
                  hop_bytes[idx] = '0;
                  push_send(dst, fin, fin + 1);
               end
            end
         end else if (cfg_mode != a2a_trk_pkg::MODE_RING) begin
            rank_bytes[dst] = sat_add(rank_bytes[dst], size);
            if (64'(rank_bytes[dst]) >= 64'(cfg_chunk) * (srcs_done[dst] + 1)) begin
               if (srcs_done[dst] < 7) srcs_done[dst]++;
               if (srcs_done[dst] >= n - 1) count_rank_done(n);
            end
         end else begin
            step_bytes[dst] = sat_add(step_bytes[dst], size);
            if (step_bytes[dst] >= cfg_chunk) begin
               step_bytes[dst] = '0;
               if (step_done[dst] < 7) step_done[dst]++;
               step = step_done[dst];
               if (step >= n - 1) count_rank_done(n);
               else push_send(dst, (dst + step + 1) % n, step + 1);
            end
         end
      end
      if (item_cmds.size() > 0) item_cmds[item_cmds.size() - 1].last = 1'b1;
      foreach (item_cmds[i]) expected_cmds.push_back(item_cmds[i]);
   endtask

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   // Offer one request transaction; predict it, then hold it until taken.
   task automatic send_req(logic op, int src, int dst, logic [15:0] flow,
                           logic isd, logic [31:0] hdr, logic [31:0] pkt);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      track_item(op, src, dst, flow, isd, hdr, pkt);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, pkt, hdr, flow, 3'(dst), 3'(src)};
      req_tuser  <= {isd, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Drop valid and wait until every expected response has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_cmds.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Hold one register write until taken; the caller drops valid afterwards.
   task automatic write_csr(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         a2a_trk_pkg::REG_GPU_COUNT:     cfg_gpus  = val[3:0];
         a2a_trk_pkg::REG_CHUNK_BYTES:   cfg_chunk = val;
         a2a_trk_pkg::REG_MODE:          cfg_mode  = val[1:0];
         a2a_trk_pkg::REG_GRID_COLS:     cfg_cols  = val[3:0];
         a2a_trk_pkg::REG_WIRE_PROTOCOL: cfg_proto = val[1:0];
         default: ;
      endcase
   endtask

   task automatic configure(int gpus, logic [31:0] chunk, logic [1:0] md,
                            int cols, logic [1:0] proto);
      drain();
      write_csr(a2a_trk_pkg::REG_GPU_COUNT, 32'(gpus));
      write_csr(a2a_trk_pkg::REG_CHUNK_BYTES, chunk);
      write_csr(a2a_trk_pkg::REG_MODE, 32'(md));
      write_csr(a2a_trk_pkg::REG_GRID_COLS, 32'(cols));
      write_csr(a2a_trk_pkg::REG_WIRE_PROTOCOL, 32'(proto));
      csr_valid <= 1'b0;
   endtask

   // One random request, mostly well formed for the current setting.
   task automatic send_random();
      int n, src, dst;
      logic [15:0] flow;
      logic [31:0] hdr, pkt;
      n = ranks();
      if ($urandom_range(99) < 4) begin
         send_req(a2a_trk_pkg::OP_START, $urandom_range(7), $urandom_range(7),
                  16'($urandom), 1'b1, $urandom, $urandom);
         return;
      end
      src = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(n - 1);
      dst = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(n - 1);
      case ($urandom_range(3))
         0: flow = 16'($urandom);
         1: flow = a2a_trk_pkg::FIRST_HOP_MARK |
                   16'(($urandom_range(7) == 0) ? $urandom_range(8, 9)
                                                : $urandom_range(n - 1));
         default: flow = 16'($urandom_range(1, n));
      endcase
      pkt = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 2 * cfg_chunk);
      case ($urandom_range(5))
         0: hdr = 0;
         1: hdr = $urandom;
         default: hdr = $urandom_range(0, cfg_chunk);
      endcase
      send_req(a2a_trk_pkg::OP_PACKET, src, dst, flow, $urandom_range(9) != 0, hdr, pkt);
   endtask

   // Response side: random stalls plus an optional long hold-off.
   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rx_hold = rx_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
      end
   end

   // Compare every accepted response with the oldest pending command.
   always @(posedge clock) begin
      cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_cmds.size() == 0) begin
            report("unexpected response", 32'(rsp_tdata), 0);
         end else begin
            want = expected_cmds.pop_front();
            if (rsp_tuser !== want.kind) report("kind", rsp_tuser, want.kind);
            if (rsp_tdata[2:0] !== want.src) report("send_source", rsp_tdata[2:0], want.src);
            if (rsp_tdata[5:3] !== want.tgt) report("send_target", rsp_tdata[5:3], want.tgt);
            if (rsp_tdata[21:6] !== want.flow) report("send_flow", rsp_tdata[21:6], want.flow);
            if (rsp_tdata[23:22] !== want.proto)
               report("send_protocol", rsp_tdata[23:22], want.proto);
            if (rsp_tlast !== want.last) report("last", rsp_tlast, want.last);
         end
      end
   end

   // Guard against a hung handshake.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Corner cases: reset settings, clamps, ignored packets, ragged grid.
   task automatic test_directed();
      // packet before start
      send_req(a2a_trk_pkg::OP_PACKET, 1, 0, 16'h0001, 1'b1, 0, 32'd5);
      send_req(a2a_trk_pkg::OP_START, 0, 0, 0, 1'b1, 0, 0);
      send_req(a2a_trk_pkg::OP_PACKET, 0, 1, 16'hffff, 1'b1, 32'hffff_ffff, 32'hffff_ffff);
      // repeat start
      send_req(a2a_trk_pkg::OP_START, 7, 7, 16'hffff, 1'b1, 32'hffff_ffff, 0);
      configure(0, 0, 2'd3, 0, 2'd3);                       // zero chunk, mode 3
      send_req(a2a_trk_pkg::OP_START, 0, 0, 0, 1'b0, 0, 0);
      send_req(a2a_trk_pkg::OP_PACKET, 0, 1, 16'h0002, 1'b1, 0, 0);
      send_req(a2a_trk_pkg::OP_PACKET, 1, 0, 16'h0002, 1'b1, 0, 0);
      // repeat completion
      send_req(a2a_trk_pkg::OP_PACKET, 1, 0, 16'h0002, 1'b1, 0, 0);
      // rank out of range
      send_req(a2a_trk_pkg::OP_PACKET, 1, 2, 16'h0002, 1'b1, 0, 0);
      // not data
      send_req(a2a_trk_pkg::OP_PACKET, 0, 1, 16'h0002, 1'b0, 0, 0);
      // clamp to eight ranks
      configure(15, 32'd10, a2a_trk_pkg::MODE_GRID, 8, 2'd1);
      send_req(a2a_trk_pkg::OP_START, 0, 0, 0, 1'b1, 0, 0);
      // final rank out of range
      send_req(a2a_trk_pkg::OP_PACKET, 7, 3, 16'h8009, 1'b1, 32'd20, 0);
      send_req(a2a_trk_pkg::OP_PACKET, 7, 3, 16'h8005, 1'b1, 0, 32'd12);
      // ragged grid
      configure(7, 32'd4, a2a_trk_pkg::MODE_GRID, 3, 2'd2);
      send_req(a2a_trk_pkg::OP_START, 0, 0, 0, 1'b1, 0, 0);
      send_req(a2a_trk_pkg::OP_PACKET, 6, 2, 16'h8000, 1'b1, 32'd4, 0);
      send_req(a2a_trk_pkg::OP_PACKET, 1, 7, 16'h0001, 1'b1, 32'd4, 0);
      configure(8, 32'hffff_ffff, a2a_trk_pkg::MODE_RING, 1, 2'd0);
      send_req(a2a_trk_pkg::OP_START, 0, 0, 0, 1'b1, 0, 0);
      send_req(a2a_trk_pkg::OP_PACKET, 2, 3, 16'h0001, 1'b1, 32'hffff_ffff, 0);
      send_req(a2a_trk_pkg::OP_PACKET, 5, 4, 16'h0001, 1'b1, 0, 32'hffff_fffe);
   endtask

   task automatic test_random_phase(int gpus, int md, int cols, int items);
      configure(gpus, $urandom_range(1, 64), 2'(md), cols, 2'($urandom_range(3)));
      send_req(a2a_trk_pkg::OP_START, 0, 0, 0, 1'b1, 0, 0);
      repeat (items) send_random();
   endtask

   task automatic test_idling();
      send_idle_pct = 0;  rx_stall_pct = 0;
      test_random_phase($urandom_range(2, 8), a2a_trk_pkg::MODE_RING, 1, 12);
      send_idle_pct = 76; rx_stall_pct = 0;
      test_random_phase($urandom_range(2, 8), a2a_trk_pkg::MODE_DIRECT, 1, 12);
      send_idle_pct = 0;  rx_stall_pct = 76;
      test_random_phase($urandom_range(4, 8), a2a_trk_pkg::MODE_GRID,
                        $urandom_range(1, 4), 12);
      send_idle_pct = 30; rx_stall_pct = 30;
      test_random_phase($urandom_range(2, 8), a2a_trk_pkg::MODE_RING, 1, 12);
      // pause mid-stream until everything is back, then go on
      drain();
      test_random_phase($urandom_range(4, 8), a2a_trk_pkg::MODE_GRID,
                        $urandom_range(2, 3), 12);
   endtask

   // Hold the response side off long enough for the core to back up.
   task automatic test_backpressure();
      configure(8, 32'd3, a2a_trk_pkg::MODE_DIRECT, 1, 2'd1);
      rx_hold = 400;
      send_req(a2a_trk_pkg::OP_START, 0, 0, 0, 1'b1, 0, 0);
      repeat (20) send_random();
   endtask

   // Push one byte counter into saturation, then keep completing on it.
   task automatic test_saturation();
      send_idle_pct = 0; rx_stall_pct = 0;
      configure(2, 32'hffff_ffff, a2a_trk_pkg::MODE_DIRECT, 1, 2'd3);
      repeat (260)
         send_req(a2a_trk_pkg::OP_PACKET, 1, 0, 16'h0001, 1'b1, 32'hffff_ffff, 0);
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= '0;
      csr_data   <= '0;
      cycles = 0; errors = 0; rx_hold = 0;
      send_idle_pct = 0; rx_stall_pct = 0;
      cfg_gpus = 2; cfg_chunk = 0; cfg_mode = a2a_trk_pkg::MODE_RING; cfg_cols = 1;
      cfg_proto = 0;
      for (int i = 0; i < NR; i++) begin
         step_done[i] = '0; step_bytes[i] = '0; rank_bytes[i] = '0; srcs_done[i] = '0;
      end
      for (int i = 0; i < NR * NR; i++) hop_bytes[i] = '0;
      done_ranks = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_idling();
      test_backpressure();
      test_saturation();

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
